>>> rtl/bsf_pkg.sv
// Shared constants and types for the byte stuffing framer.
package bsf_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SEQ_DEPTH = 8;
    localparam int unsigned SEQ_IDX_W = $clog2(SEQ_DEPTH);
    localparam int unsigned SEQ_LEN_W = SEQ_IDX_W + 1;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] FLAG_RST        = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RST      = 8'h7D;
    localparam logic [BYTE_W-1:0] ADDRESS_RST     = 8'h03;
    localparam logic [BYTE_W-1:0] CONTROL_RST     = 8'h00;
    localparam logic [BYTE_W-1:0] STUFF_FLAG_CODE = 8'h5E;
    localparam logic [BYTE_W-1:0] STUFF_ESC_CODE  = 8'h5D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLAG    = 2'd0,
        CFG_ESCAPE  = 2'd1,
        CFG_ADDRESS = 2'd2,
        CFG_CONTROL = 2'd3
    } t_cfg_reg;

    typedef logic [BYTE_W-1:0] t_seq [SEQ_DEPTH];

endpackage

>>> rtl/byte_stuffing_framer.sv
// HDLC-style byte stuffing framer: header, stuffing, trailer, closing flag.
//
// Each accepted payload word is expanded combinationally into a sequence of one
// to eight line bytes (header on the first word of a frame, escape pair for a
// flag or escape byte, check byte and closing flag after the last word). The
// sequence buffer then hands one byte per cycle to the output register while
// the output is not stalled. A plain mid-frame byte makes 1 line byte, a
// stuffed one 2, and a single-byte frame that needs stuffing up to 8. The
// next word is taken in the cycle the last byte of the current sequence moves
// to the output register, so no bubble is left between items. Configuration
// writes are taken in any cycle (ready is tied high) and must only be issued
// while the block is idle.
module byte_stuffing_framer
    import bsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_payload_byte,
    input  logic                 i_end_of_payload,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_line_byte,
    output logic                 o_frame_end,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic [BYTE_W-1:0]    r_flag, r_escape, r_address, r_control;
    logic                 r_in_frame;

    t_seq                 r_buf_bytes;
    logic [SEQ_LEN_W-1:0] r_buf_len;
    logic [SEQ_IDX_W-1:0] r_buf_idx;
    logic                 r_buf_close;
    logic                 r_buf_vld;

    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_end;
    logic                 r_out_vld;

    t_seq                 n_bytes;
    logic [SEQ_LEN_W-1:0] n_len;
    logic [BYTE_W-1:0]    check;
    logic                 out_free;
    logic                 emit;
    logic                 emit_last;
    logic                 in_accept;
    logic                 cfg_write;

    assign check     = r_address ^ r_control;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign emit      = r_buf_vld && out_free;
    assign emit_last = emit && ({1'b0, r_buf_idx} == (r_buf_len - 1'b1));
    assign o_in_stall = r_buf_vld && !emit_last;
    assign in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write = i_cfg_valid && o_cfg_ready;

    assign o_out_valid = r_out_vld;
    assign o_line_byte = r_out_byte;
    assign o_frame_end = r_out_end;

    // Expand one payload word into its line byte sequence.
    always_comb begin
        logic [SEQ_LEN_W-1:0] pos;
        pos = '0;
        n_bytes = '{default: '0};
        if (!r_in_frame) begin
            n_bytes[0] = r_flag;
            n_bytes[1] = r_address;
            n_bytes[2] = r_control;
            n_bytes[3] = check;
            pos = SEQ_LEN_W'(4);
        end
        if (i_payload_byte == r_flag) begin
            n_bytes[pos[SEQ_IDX_W-1:0]]        = r_escape;
            n_bytes[pos[SEQ_IDX_W-1:0] + 1'b1] = STUFF_FLAG_CODE;
            pos = pos + SEQ_LEN_W'(2);
        end else if (i_payload_byte == r_escape) begin
            n_bytes[pos[SEQ_IDX_W-1:0]]        = r_escape;
            n_bytes[pos[SEQ_IDX_W-1:0] + 1'b1] = STUFF_ESC_CODE;
            pos = pos + SEQ_LEN_W'(2);
        end else begin
            n_bytes[pos[SEQ_IDX_W-1:0]] = i_payload_byte;
            pos = pos + SEQ_LEN_W'(1);
        end
        if (i_end_of_payload) begin
            n_bytes[pos[SEQ_IDX_W-1:0]]        = check;
            n_bytes[pos[SEQ_IDX_W-1:0] + 1'b1] = r_flag;
            pos = pos + SEQ_LEN_W'(2);
        end
        n_len = pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag    <= FLAG_RST;
            r_escape  <= ESCAPE_RST;
            r_address <= ADDRESS_RST;
            r_control <= CONTROL_RST;
        end else if (cfg_write) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FLAG:    r_flag    <= i_cfg_data;
                CFG_ESCAPE:  r_escape  <= i_cfg_data;
                CFG_ADDRESS: r_address <= i_cfg_data;
                CFG_CONTROL: r_control <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequence buffer control: load on accept, advance on each emitted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_vld  <= 1'b0;
            r_buf_idx  <= '0;
            r_in_frame <= 1'b0;
        end else if (in_accept) begin
            r_buf_vld  <= 1'b1;
            r_buf_idx  <= '0;
            r_in_frame <= !i_end_of_payload;
        end else if (emit_last) begin
            r_buf_vld <= 1'b0;
            r_buf_idx <= '0;
        end else if (emit) begin
            r_buf_idx <= r_buf_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_buf_bytes <= n_bytes;
            r_buf_len   <= n_len;
            r_buf_close <= i_end_of_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= emit;
        end
    end

    // Hold the output word while stalled.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= r_buf_bytes[r_buf_idx];
            r_out_end  <= r_buf_close && emit_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_vld |-> ({1'b0, r_buf_idx} < r_buf_len))
        else $error("sequence index beyond sequence length");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_buf_vld && r_buf_len != '0))
        else $error("accepted word produced an empty sequence");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_buf_vld |-> !o_in_stall)
        else $error("input stalled with empty sequence buffer");

    a_close_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_line_byte == r_flag))
        else $error("frame end marked on a byte other than the flag");

    a_close_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_last && r_buf_close) |-> !r_in_frame)
        else $error("frame still open after closing flag");
`endif

endmodule

>>> sim/tb_byte_stuffing_framer.sv
// Self-checking testbench for byte_stuffing_framer: directed frames, register changes, random traffic.
module tb_byte_stuffing_framer;
    import bsf_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              frame_end;
    } t_line_word;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_payload_byte = '0;
    logic                 i_end_of_payload = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [BYTE_W-1:0]    o_line_byte;
    logic                 o_frame_end;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data = '0;

    // Mirror of the framer registers and its frame state
    logic [BYTE_W-1:0] cfg_flag    = FLAG_RST;
    logic [BYTE_W-1:0] cfg_escape  = ESCAPE_RST;
    logic [BYTE_W-1:0] cfg_address = ADDRESS_RST;
    logic [BYTE_W-1:0] cfg_control = CONTROL_RST;
    logic              frame_open  = 1'b0;

    t_line_word line_byte_q[$];
    int unsigned mismatch_count = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned snk_stall_pct  = 0;

    byte_stuffing_framer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_payload_byte   (i_payload_byte),
        .i_end_of_payload (i_end_of_payload),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_line_byte      (o_line_byte),
        .o_frame_end      (o_frame_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("byte_stuffing_framer: mismatch");
        $finish;
    end

    function automatic void push_line(input logic [BYTE_W-1:0] b, input logic fe);
        line_byte_q.push_back('{line_byte: b, frame_end: fe});
    endfunction

    // Expand one accepted payload word into the line bytes it should produce
    function automatic void expand_payload(input logic [BYTE_W-1:0] b, input logic last);
        if (!frame_open) begin
            push_line(cfg_flag, 1'b0);
            push_line(cfg_address, 1'b0);
            push_line(cfg_control, 1'b0);
            push_line(cfg_address ^ cfg_control, 1'b0);
            frame_open = 1'b1;
        end
        // flag wins when flag and escape share a value
        if (b == cfg_flag) begin
            push_line(cfg_escape, 1'b0);
            push_line(STUFF_FLAG_CODE, 1'b0);
        end else if (b == cfg_escape) begin
            push_line(cfg_escape, 1'b0);
            push_line(STUFF_ESC_CODE, 1'b0);
        end else begin
            push_line(b, 1'b0);
        end
        if (last) begin
            push_line(cfg_address ^ cfg_control, 1'b0);
            push_line(cfg_flag, 1'b1);
            frame_open = 1'b0;
        end
    endfunction

    // Check every line byte taken from the framer; also drive the output stall
    always @(posedge i_clk) begin
        t_line_word exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (line_byte_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected line byte %02h frame_end %0b", o_line_byte,
                             o_frame_end);
            end else begin
                exp_word = line_byte_q.pop_front();
                if (o_line_byte !== exp_word.line_byte || o_frame_end !== exp_word.frame_end)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("line byte: expected %02h/%0b, got %02h/%0b",
                                 exp_word.line_byte, exp_word.frame_end, o_line_byte,
                                 o_frame_end);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    // Present one payload word and wait for it to be taken; valid stays high afterwards
    task automatic send_payload(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_payload_byte   <= b;
        i_end_of_payload <= last;
        do @(posedge i_clk); while (o_in_stall);
        expand_payload(b, last);
    endtask

    // Drop valid and wait until every expected line byte has come out
    task automatic drain;
        i_in_valid <= 1'b0;
        while (line_byte_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [BYTE_W-1:0] f, input logic [BYTE_W-1:0] e,
                                   input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] c);
        t_cfg_reg          regs [4] = '{CFG_FLAG, CFG_ESCAPE, CFG_ADDRESS, CFG_CONTROL};
        logic [BYTE_W-1:0] vals [4];
        logic [1:0]        k;
        vals = '{f, e, a, c};
        drain();
        for (int i = 0; i < 4; i++) begin
            k = 2'(i);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (regs[k])
                CFG_FLAG:    cfg_flag    = vals[k];
                CFG_ESCAPE:  cfg_escape  = vals[k];
                CFG_ADDRESS: cfg_address = vals[k];
                CFG_CONTROL: cfg_control = vals[k];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_payload;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return cfg_flag;
        else if (r < 35)
            return cfg_escape;
        else
            return BYTE_W'($urandom_range(255));
    endfunction

    task automatic test_reset_registers;
        send_payload(8'h00, 1'b1);
        send_payload(FLAG_RST, 1'b0);
        send_payload(ESCAPE_RST, 1'b0);
        send_payload(8'hFF, 1'b0);
        send_payload(STUFF_FLAG_CODE, 1'b1);
    endtask

    task automatic test_register_extremes;
        write_registers(8'h00, 8'hFF, 8'hFF, 8'h00);
        send_payload(8'h00, 1'b0);
        send_payload(8'hFF, 1'b0);
        send_payload(8'h7E, 1'b1);
        write_registers(8'hFF, 8'h00, 8'h00, 8'hFF);
        send_payload(8'hFF, 1'b1);
        send_payload(8'h00, 1'b1);
    endtask

    task automatic test_flag_equals_escape;
        write_registers(8'h55, 8'h55, 8'hA5, 8'h5A);
        send_payload(8'h55, 1'b1);
        send_payload(8'hAA, 1'b0);
        send_payload(8'h55, 1'b1);
    endtask

    // Change all registers while a frame is open; trailer uses the new address and control
    task automatic test_write_mid_frame;
        write_registers(FLAG_RST, ESCAPE_RST, ADDRESS_RST, CONTROL_RST);
        send_payload(8'h10, 1'b0);
        send_payload(8'h7E, 1'b0);
        write_registers(8'h33, 8'hCC, 8'h81, 8'h18);
        send_payload(8'h7E, 1'b0);
        send_payload(8'h33, 1'b0);
        send_payload(8'hCC, 1'b1);
    endtask

    task automatic test_random_frames(input int unsigned src_pct, input int unsigned snk_pct,
                                      input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            for (int unsigned k = 1; k <= len; k++)
                send_payload(pick_payload(), k == len);
            sent += len;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_registers();
        test_register_extremes();
        test_flag_equals_escape();
        test_write_mid_frame();

        write_registers(FLAG_RST, ESCAPE_RST, ADDRESS_RST, CONTROL_RST);
        test_random_frames(26, 70, 130);
        write_registers(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                        BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        test_random_frames(70, 26, 130);
        write_registers(8'h00, 8'h01, 8'hFF, 8'hFF);
        test_random_frames(0, 0, 60);
        write_registers(8'hFE, 8'hFF, 8'h00, 8'h00);
        test_random_frames(0, 0, 60);

        drain();
        // allow for anything still in flight
        repeat (16) @(posedge i_clk);
        if (line_byte_q.size() != 0) begin
            mismatch_count++;
            $display("%0d expected line bytes never arrived", line_byte_q.size());
        end
        if (mismatch_count == 0)
            $display("byte_stuffing_framer: match");
        else
            $display("byte_stuffing_framer: mismatch");
        $finish;
    end

endmodule
